@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ design/ptrs_pkg.sv @@
// Types, constants and helpers of the periodic task release scheduler
`timescale 1ns / 1ps

package ptrs_pkg;

  // Slot table geometry
  localparam int unsigned TASK_SLOTS  = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned STEP_W      = $clog2(PERIOD_W);

  // Action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_SUSPEND = 3'd2;
  localparam logic [2:0] ACT_RESUME  = 3'd3;
  localparam logic [2:0] ACT_DELETE  = 3'd4;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [7:0]          task_slot;
    logic [PERIOD_W-1:0] period_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] due_task;
    logic       last_due;
  } out_item_t;

  // Status of the shared remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

  // Low three bits of a slot index
  function automatic logic [2:0] due_code(slot_idx_t idx);
    logic [SLOT_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

  // Slot number lies inside the table
  function automatic logic slot_in_range(logic [7:0] slot);
    return (32'(slot) < TASK_SLOTS);
  endfunction

endpackage

@@ design/ptrs_rem.sv @@
// Bit-serial 16-bit remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module ptrs_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0] dividend_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0] divisor_i,
  output ptrs_pkg::rem_sts_t            sts_o,
  output logic [ptrs_pkg::PERIOD_W-1:0] rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [ptrs_pkg::STEP_W-1:0]   step_q;
  logic [ptrs_pkg::PERIOD_W-1:0] rem_q;
  logic [ptrs_pkg::PERIOD_W-1:0] dvd_q;
  logic [ptrs_pkg::PERIOD_W-1:0] dvs_q;

  logic [ptrs_pkg::PERIOD_W:0]   shifted;
  logic [ptrs_pkg::PERIOD_W:0]   diff;
  logic [ptrs_pkg::PERIOD_W-1:0] rem_step;

  // Restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem_q, dvd_q[ptrs_pkg::PERIOD_W-1]};
    diff     = shifted - {1'b0, dvs_q};
    rem_step = (shifted >= {1'b0, dvs_q}) ? diff[ptrs_pkg::PERIOD_W-1:0]
                                          : shifted[ptrs_pkg::PERIOD_W-1:0];
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + ptrs_pkg::STEP_W'(1);
      if (step_q == ptrs_pkg::STEP_W'(ptrs_pkg::PERIOD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_step;
      dvd_q <= {dvd_q[ptrs_pkg::PERIOD_W-2:0], 1'b0};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

@@ design/periodic_task_release_scheduler.sv @@
// Top level of the periodic task release scheduler
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// The input channel (in_valid_i / in_stall_o / in_data_i) takes one action per
// transfer: tick, create, suspend, resume or delete of a task slot. Create,
// suspend, resume and delete complete in the accepting cycle and give no result.
// A tick bumps the 16-bit wrapping tick counter and then walks the slots in
// order; each present, resumed slot with a nonzero period is checked by the
// bit-serial remainder unit (per slot: table read, check, one remainder step
// per tick counter bit and the done cycle; a further step when the slot is
// due). Idle slots pass through the table read and check only.
// Each due slot leaves as one transfer on the output channel
// (out_valid_o / out_stall_i / out_data_o); the final one of a tick carries
// last_due. A due slot is held until the next due slot is found or the walk
// ends. in_stall_o stays high for the whole tick. A stall on the output holds
// the result register and pauses the slot walk when a second due slot is
// waiting. Reset clears the counter, all present and resumed marks and both
// channels.
module periodic_task_release_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptrs_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_DIV,
    ST_DUE,
    ST_FLUSH
  } state_e;

  state_e                             state_q, state_d;
  logic [ptrs_pkg::PERIOD_W-1:0]      tick_q, tick_d;
  logic [ptrs_pkg::TASK_SLOTS-1:0]    present_q, present_d;
  logic [ptrs_pkg::TASK_SLOTS-1:0]    resumed_q, resumed_d;
  ptrs_pkg::slot_idx_t                scan_q, scan_d;
  ptrs_pkg::slot_idx_t                pend_q, pend_d;
  logic                               pend_vld_q, pend_vld_d;
  logic [ptrs_pkg::CNT_W-1:0]         found_q, found_d;
  logic                               out_vld_q, out_vld_d;
  ptrs_pkg::out_item_t                out_q, out_d;

  logic [ptrs_pkg::PERIOD_W-1:0]      period_mem [ptrs_pkg::TASK_SLOTS];
  logic [ptrs_pkg::PERIOD_W-1:0]      period_rd_q;
  logic                               mem_we;

  ptrs_pkg::slot_idx_t                wr_idx;
  logic                               wr_ok;
  logic                               out_free;
  logic                               last_slot;
  logic [ptrs_pkg::CNT_W-1:0]         found_inc;
  logic                               found_full;
  logic                               rem_start;
  ptrs_pkg::rem_sts_t                 rem_sts;
  logic [ptrs_pkg::PERIOD_W-1:0]      rem_val;

  // Shared remainder unit
  ptrs_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (tick_q),
    .divisor_i  (period_rd_q),
    .sts_o      (rem_sts),
    .rem_o      (rem_val)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign wr_idx     = in_data_i.task_slot[ptrs_pkg::SLOT_W-1:0];
  assign wr_ok      = ptrs_pkg::slot_in_range(in_data_i.task_slot);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign last_slot  = (scan_q == ptrs_pkg::SLOT_W'(ptrs_pkg::TASK_SLOTS - 1));
  assign found_inc  = found_q + ptrs_pkg::CNT_W'(1);
  assign found_full = (found_inc == ptrs_pkg::CNT_W'(ptrs_pkg::MAX_RESULTS));

  // Period table: written by create, read at the scan slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      period_mem[wr_idx] <= in_data_i.period_ticks;
    end
    period_rd_q <= period_mem[scan_q];
  end

  // Sequencer next state; one due slot is held back so the last can be flagged
  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    present_d  = present_q;
    resumed_d  = resumed_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    found_d    = found_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    mem_we     = 1'b0;
    rem_start  = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            ptrs_pkg::ACT_TICK: begin
              tick_d  = tick_q + ptrs_pkg::PERIOD_W'(1);
              scan_d  = '0;
              found_d = '0;
              state_d = ST_FETCH;
            end
            ptrs_pkg::ACT_CREATE: begin
              if (wr_ok) begin
                mem_we            = 1'b1;
                present_d[wr_idx] = 1'b1;
                resumed_d[wr_idx] = 1'b1;
              end
            end
            ptrs_pkg::ACT_SUSPEND: begin
              if (wr_ok) begin
                resumed_d[wr_idx] = 1'b0;
              end
            end
            ptrs_pkg::ACT_RESUME: begin
              if (wr_ok) begin
                resumed_d[wr_idx] = 1'b1;
              end
            end
            ptrs_pkg::ACT_DELETE: begin
              if (wr_ok) begin
                present_d[wr_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // period read issued at this edge
      ST_FETCH: begin
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if (present_q[scan_q] && resumed_q[scan_q] && (period_rd_q != '0)) begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end else if (last_slot) begin
          state_d = ST_FLUSH;
        end else begin
          scan_d  = scan_q + ptrs_pkg::SLOT_W'(1);
          state_d = ST_FETCH;
        end
      end

      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_val == '0) begin
            state_d = ST_DUE;
          end else if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            scan_d  = scan_q + ptrs_pkg::SLOT_W'(1);
            state_d = ST_FETCH;
          end
        end
      end

      // Hand the held slot out, hold this one
      ST_DUE: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d      = 1'b1;
            out_d.due_task = ptrs_pkg::due_code(pend_q);
            out_d.last_due = 1'b0;
          end
          pend_d     = scan_q;
          pend_vld_d = 1'b1;
          found_d    = found_inc;
          if (last_slot || found_full) begin
            state_d = ST_FLUSH;
          end else begin
            scan_d  = scan_q + ptrs_pkg::SLOT_W'(1);
            state_d = ST_FETCH;
          end
        end
      end

      // Final release of the tick carries the last flag
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d      = 1'b1;
          out_d.due_task = ptrs_pkg::due_code(pend_q);
          out_d.last_due = 1'b1;
          pend_vld_d     = 1'b0;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_q     <= '0;
      present_q  <= '0;
      resumed_q  <= '0;
      scan_q     <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      found_q    <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      tick_q     <= tick_d;
      present_q  <= present_d;
      resumed_q  <= resumed_d;
      scan_q     <= scan_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
    end
  end

  // Checks
  `ASSERT_PROP(a_idle_no_pend, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_vld_q, "held slot left over after tick")
  `ASSERT_NEVER(a_found_cap, clk_i, rst_ni, found_q > ptrs_pkg::CNT_W'(ptrs_pkg::MAX_RESULTS), "release count over limit")
  `ASSERT_PROP(a_rem_in_div, clk_i, rst_ni, rem_sts.busy |-> (state_q == ST_DIV), "remainder unit busy outside divide state")
  `ASSERT_PROP(a_tick_bump, clk_i, rst_ni, (in_valid_i && !in_stall_o && (in_data_i.action == ptrs_pkg::ACT_TICK)) |=> (tick_q == $past(tick_q) + 16'd1), "tick counter not advanced")

endmodule
